@@ sv/mer_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg: shared constants for the midpoint ellipse rasterizer
// Field widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package mer_pkg;

  // Payload and configuration widths
  localparam int AXIS_W    = 10;
  localparam int COORD_W   = 11;
  localparam int CFG_IDX_W = 1;

  // Datapath widths: squares of an axis, multiplier operands, wide accumulators
  localparam int SQ_W   = 2 * AXIS_W;
  localparam int MUL_W  = 24;
  localparam int WIDE_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEMI_AXIS_Y = 1'b1;

  // Configuration reset values
  localparam logic [AXIS_W-1:0] SEMI_AXIS_X_RST = 10'd350;
  localparam logic [AXIS_W-1:0] SEMI_AXIS_Y_RST = 10'd250;

endpackage

@@ sv/mer_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_in_if: command channel of the ellipse rasterizer
// Valid/ready channel carrying one restart-or-advance command per transfer.
// ----------------------------------------------------------------------------
interface mer_in_if;

  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);

endinterface

@@ sv/mer_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_out_if: pixel channel of the ellipse rasterizer
// Valid/ready channel carrying one mirrored outline pixel per transfer.
// ----------------------------------------------------------------------------
interface mer_out_if import mer_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic                      last_of_set;
  logic                      outline_done;

  modport source (output valid, output point_x, output point_y, output last_of_set,
                  output outline_done, input ready);
  modport sink   (input valid, input point_x, input point_y, input last_of_set,
                  input outline_done, output ready);

endinterface

@@ sv/midpoint_ellipse_rasterizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer: two-region midpoint ellipse walker
// Walks the outline of an origin-centred ellipse, one point per advance command.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_write/cfg_index/cfg_data set semi-axes a (index 0) and b (index 1);
//   they are sampled at the next restart command.
//   in_ch carries commands: restart=1 reloads the walk at (0,b) and yields no
//   pixels; restart=0 advances one outline point and yields four mirrored
//   pixels on out_ch in the order (x,y), (x,-y), (-x,-y), (-x,y), the fourth
//   flagged last_of_set. outline_done marks the final set of the ellipse.
//   An advance with no walk active is absorbed with no pixels.
// Timing: one command at a time; in_ch.ready is high only when idle.
//   All arithmetic goes through one shared 24x24 multiplier and one 48-bit
//   adder, one operation per cycle under the sequencer.
//   A restart runs the square, gradient and decision states; an advance in an
//   active walk runs its region's update states (the region change needs five
//   multiplies), then offers four pixels. The next command is taken once the
//   sequencer is back in idle.
// Stall: a pixel holds on out_ch until taken; the sequencer waits with it.
// Reset: synchronous rst returns the semi-axes to 350/250 and the walk to
//   idle; the first advance needs a restart before it yields pixels.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer import mer_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  mer_in_if.sink               in_ch,
  mer_out_if.source            out_ch,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [AXIS_W-1:0]    cfg_data
);

  localparam int ST_W = 27;

  typedef enum logic [ST_W-1:0] {
    S_IDLE   = 27'd1 << 0,
    S_RS_M0  = 27'd1 << 1,
    S_RS_M1  = 27'd1 << 2,
    S_RS_M2  = 27'd1 << 3,
    S_RS_A0  = 27'd1 << 4,
    S_RS_A1  = 27'd1 << 5,
    S_RS_DIV = 27'd1 << 6,
    S_R1_CMP = 27'd1 << 7,
    S_R1_GX  = 27'd1 << 8,
    S_R1_D0  = 27'd1 << 9,
    S_R1_D1  = 27'd1 << 10,
    S_R1_GY  = 27'd1 << 11,
    S_R1_D2  = 27'd1 << 12,
    S_TR_M0  = 27'd1 << 13,
    S_TR_M1  = 27'd1 << 14,
    S_TR_M2  = 27'd1 << 15,
    S_TR_M3  = 27'd1 << 16,
    S_TR_M4  = 27'd1 << 17,
    S_TR_M5  = 27'd1 << 18,
    S_TR_DIV = 27'd1 << 19,
    S_R2_GY  = 27'd1 << 20,
    S_R2_D0  = 27'd1 << 21,
    S_R2_D1  = 27'd1 << 22,
    S_R2_GX  = 27'd1 << 23,
    S_R2_D2  = 27'd1 << 24,
    S_R2_FIN = 27'd1 << 25,
    S_EMIT   = 27'd1 << 26
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2
  } phase_t;

  // Configuration
  logic [AXIS_W-1:0] axis_x;
  logic [AXIS_W-1:0] axis_y;

  // Control
  state_t     state;
  phase_t     phase;
  logic [1:0] emit_idx;
  logic       dneg;
  logic       done_flag;

  // Walk state
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic signed [COORD_W-1:0] emit_x;
  logic signed [COORD_W-1:0] emit_y;
  logic signed [WIDE_W-1:0]  decision;
  logic signed [WIDE_W-1:0]  grad_x;
  logic signed [WIDE_W-1:0]  grad_y;
  logic signed [WIDE_W-1:0]  acc;
  logic [SQ_W-1:0]           sq_a;
  logic [SQ_W-1:0]           sq_b;

  // Shared arithmetic unit
  logic [MUL_W-1:0]         mul_x;
  logic [MUL_W-1:0]         mul_y;
  logic [WIDE_W-1:0]        prod;
  logic signed [WIDE_W-1:0] add_a;
  logic signed [WIDE_W-1:0] add_b;
  logic                     add_sub;
  logic signed [WIDE_W-1:0] add_sum;

  logic                     in_xfer;
  logic                     out_xfer;
  logic [AXIS_W-1:0]        ty_abs;
  logic [MUL_W/2-1:0]       tx;
  logic                     y_le_zero;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_ch.valid && out_ch.ready;
  assign tx        = {cur_x, 1'b1};
  assign ty_abs    = (cur_y == '0) ? AXIS_W'(1) : AXIS_W'(cur_y - COORD_W'(1));
  assign y_le_zero = (cur_y <= 0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_x <= SEMI_AXIS_X_RST;
      axis_y <= SEMI_AXIS_Y_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SEMI_AXIS_X: axis_x <= cfg_data;
        REG_SEMI_AXIS_Y: axis_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      S_RS_M0: begin mul_x = MUL_W'(axis_x); mul_y = MUL_W'(axis_x); end
      S_RS_M1: begin mul_x = MUL_W'(axis_y); mul_y = MUL_W'(axis_y); end
      S_RS_M2: begin mul_x = MUL_W'(sq_a);   mul_y = MUL_W'(axis_y); end
      S_TR_M0: begin mul_x = MUL_W'(tx);     mul_y = MUL_W'(tx);     end
      S_TR_M1: begin mul_x = MUL_W'(sq_b);   mul_y = prod[MUL_W-1:0]; end
      S_TR_M2: begin mul_x = MUL_W'(ty_abs); mul_y = MUL_W'(ty_abs); end
      S_TR_M3: begin mul_x = MUL_W'(sq_a);   mul_y = prod[MUL_W-1:0]; end
      S_TR_M4: begin mul_x = MUL_W'(sq_a);   mul_y = MUL_W'(sq_b);   end
      default: ;
    endcase
  end

  // Registered multiplier
  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  // Adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state)
      S_RS_A0: begin
        add_a   = WIDE_W'({sq_b, 2'b00});
        add_b   = $signed({prod[WIDE_W-3:0], 2'b00});
        add_sub = 1'b1;
      end
      S_RS_A1:  begin add_a = acc; add_b = WIDE_W'(sq_a); end
      S_RS_DIV, S_TR_DIV: begin
        // bias negative values so the shift truncates toward zero
        add_a = acc;
        add_b = acc[WIDE_W-1] ? WIDE_W'(3) : '0;
      end
      S_R1_CMP: begin add_a = grad_x; add_b = grad_y; add_sub = 1'b1; end
      S_R1_GX, S_R2_GX: begin add_a = grad_x; add_b = WIDE_W'({sq_b, 1'b0}); end
      S_R1_D0, S_R2_D2: begin add_a = decision; add_b = grad_x; end
      S_R1_D1:  begin add_a = decision; add_b = WIDE_W'(sq_b); end
      S_R1_GY, S_R2_GY: begin
        add_a   = grad_y;
        add_b   = WIDE_W'({sq_a, 1'b0});
        add_sub = 1'b1;
      end
      S_R1_D2, S_R2_D0: begin add_a = decision; add_b = grad_y; add_sub = 1'b1; end
      S_R2_D1:  begin add_a = decision; add_b = WIDE_W'(sq_a); end
      S_TR_M2:  begin add_a = $signed(prod); end
      S_TR_M4:  begin add_a = acc; add_b = $signed({prod[WIDE_W-3:0], 2'b00}); end
      S_TR_M5: begin
        add_a   = acc;
        add_b   = $signed({prod[WIDE_W-3:0], 2'b00});
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_IDLE;
      emit_idx  <= '0;
      dneg      <= 1'b0;
      done_flag <= 1'b0;
      grad_x    <= '0;
      grad_y    <= '0;
      decision  <= '0;
      cur_x     <= '0;
      cur_y     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            dneg <= decision[WIDE_W-1];
            if (in_ch.restart) begin
              state <= S_RS_M0;
            end else begin
              unique case (phase)
                PH_ONE: begin
                  emit_x <= cur_x;
                  emit_y <= cur_y;
                  state  <= S_R1_CMP;
                end
                PH_TWO:  state <= S_R2_GY;
                default: state <= S_IDLE;
              endcase
            end
          end
        end
        // restart: squares, initial gradient and decision
        S_RS_M0: state <= S_RS_M1;
        S_RS_M1: begin
          sq_a  <= prod[SQ_W-1:0];
          state <= S_RS_M2;
        end
        S_RS_M2: begin
          sq_b  <= prod[SQ_W-1:0];
          state <= S_RS_A0;
        end
        S_RS_A0: begin
          grad_y <= $signed({prod[WIDE_W-2:0], 1'b0});
          acc    <= add_sum;
          state  <= S_RS_A1;
        end
        S_RS_A1: begin
          acc   <= add_sum;
          state <= S_RS_DIV;
        end
        S_RS_DIV: begin
          decision <= add_sum >>> 2;
          cur_x    <= '0;
          cur_y    <= COORD_W'(axis_y);
          grad_x   <= '0;
          phase    <= PH_ONE;
          state    <= S_IDLE;
        end
        // region one step
        S_R1_CMP: begin
          done_flag <= 1'b0;
          state     <= add_sum[WIDE_W-1] ? S_R1_GX : S_TR_M0;
        end
        S_R1_GX: begin
          grad_x <= add_sum;
          cur_x  <= cur_x + COORD_W'(1);
          state  <= S_R1_D0;
        end
        S_R1_D0: begin
          decision <= add_sum;
          state    <= S_R1_D1;
        end
        S_R1_D1: begin
          decision <= add_sum;
          state    <= dneg ? S_EMIT : S_R1_GY;
        end
        S_R1_GY: begin
          grad_y <= add_sum;
          cur_y  <= cur_y - COORD_W'(1);
          state  <= S_R1_D2;
        end
        S_R1_D2: begin
          decision <= add_sum;
          state    <= S_EMIT;
        end
        // region change: decision re-seeded from the midpoint below
        S_TR_M0: begin
          done_flag <= y_le_zero;
          state     <= S_TR_M1;
        end
        S_TR_M1: state <= S_TR_M2;
        S_TR_M2: begin
          acc   <= add_sum;
          state <= S_TR_M3;
        end
        S_TR_M3: state <= S_TR_M4;
        S_TR_M4: begin
          acc   <= add_sum;
          state <= S_TR_M5;
        end
        S_TR_M5: begin
          acc   <= add_sum;
          state <= S_TR_DIV;
        end
        S_TR_DIV: begin
          decision <= add_sum >>> 2;
          phase    <= done_flag ? PH_IDLE : PH_TWO;
          state    <= S_EMIT;
        end
        // region two step
        S_R2_GY: begin
          grad_y <= add_sum;
          cur_y  <= cur_y - COORD_W'(1);
          state  <= S_R2_D0;
        end
        S_R2_D0: begin
          decision <= add_sum;
          state    <= S_R2_D1;
        end
        S_R2_D1: begin
          decision <= add_sum;
          state    <= dneg ? S_R2_GX : S_R2_FIN;
        end
        S_R2_GX: begin
          grad_x <= add_sum;
          cur_x  <= cur_x + COORD_W'(1);
          state  <= S_R2_D2;
        end
        S_R2_D2: begin
          decision <= add_sum;
          state    <= S_R2_FIN;
        end
        S_R2_FIN: begin
          emit_x    <= cur_x;
          emit_y    <= cur_y;
          done_flag <= y_le_zero;
          phase     <= y_le_zero ? PH_IDLE : PH_TWO;
          state     <= S_EMIT;
        end
        // four mirrored pixels, one per transfer
        S_EMIT: begin
          if (out_xfer) begin
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == 2'd3) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Channel outputs
  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = (state == S_EMIT);
  assign out_ch.point_x      = emit_idx[1] ? -emit_x : emit_x;
  assign out_ch.point_y      = (emit_idx[0] ^ emit_idx[1]) ? -emit_y : emit_y;
  assign out_ch.last_of_set  = (emit_idx == 2'd3);
  assign out_ch.outline_done = done_flag;

`ifndef ASSERT_OFF
  // commands and pixels never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid)
    else $error("command accepted while pixels pending");

  // the final pixel of the outline leaves the walk idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_xfer && out_ch.last_of_set && out_ch.outline_done |=> phase == PH_IDLE)
    else $error("walk still active after final set");

  // x gradient only grows from zero during region one
  a_gx_nonneg: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ONE |-> !grad_x[WIDE_W-1])
    else $error("negative x gradient in region one");

  // a set always starts at the first mirror position
  a_set_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> emit_idx == 2'd0)
    else $error("pixel set does not start at first mirror");
`endif

endmodule

@@ verif/midpoint_ellipse_rasterizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_tb: self-checking bench for the ellipse walker
// Drives restart/advance commands over the valid/ready command channel and
// checks every pixel on the output channel against an in-bench two-region
// midpoint predictor. A short directed table covers reset values, the axis
// extremes, zero axes, restarts in both regions and advances with no walk
// active; random walks follow under several idling and stall patterns.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_tb;
  import mer_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_PAUSE    = 20;   // covers a restart or ignored advance
  localparam int RANDOM_ITEMS   = 195;
  localparam int LONG_HOLD      = 150;
  localparam int SMALL_AXIS_MAX = 40;
  localparam int CAPPED_STEPS   = 12;   // partial walks for large ellipses
  localparam int FREE_STEPS     = 400;

  // Command field values
  localparam bit ADVANCE = 1'b0;
  localparam bit RESTART = 1'b1;

  typedef enum logic [1:0] {WALK_IDLE, WALK_UPPER, WALK_LOWER} walk_t;

  typedef struct {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      last;
    logic                      done;
  } pixel_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [AXIS_W-1:0]    data;
    bit                   rs;
    bit                   has_exp;
    int                   ex;
    int                   ey;
    bit                   edone;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [AXIS_W-1:0]    cfg_data;

  mer_in_if  in_ch ();
  mer_out_if out_ch ();

  midpoint_ellipse_rasterizer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: semi-axis shadows and the walk itself
  logic [AXIS_W-1:0] axis_a_reg = SEMI_AXIS_X_RST;
  logic [AXIS_W-1:0] axis_b_reg = SEMI_AXIS_Y_RST;
  longint pos_x = 0, pos_y = 0, crit = 0, slope_x = 0, slope_y = 0;
  longint sq_a = 0, sq_b = 0;
  walk_t  walk_state = WALK_IDLE;

  pixel_t   pending_pixels[$];
  dir_row_t directed_rows[$];
  int fail_count   = 0;
  int quiet_cycles = 0;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int hold_request = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Four mirrored pixels of one outline point, in output order
  function automatic void queue_pixel_set(longint x, longint y, bit fin);
    pixel_t p;
    longint xs[4];
    longint ys[4];
    int     k;
    xs = '{x, x, -x, -x};
    ys = '{y, -y, -y, y};
    for (k = 0; k < 4; k++) begin
      p.px   = COORD_W'(xs[k]);
      p.py   = COORD_W'(ys[k]);
      p.last = (k == 3);
      p.done = fin;
      pending_pixels.push_back(p);
    end
  endfunction

  // One command through the midpoint walk; returns 1 when a point is emitted
  function automatic bit step_outline(input bit restart_cmd, output longint px,
                                      output longint py, output bit fin);
    longint a, b, tx, ty;
    px  = 0;
    py  = 0;
    fin = 1'b0;
    if (restart_cmd) begin
      a          = longint'(axis_a_reg);
      b          = longint'(axis_b_reg);
      sq_a       = a * a;
      sq_b       = b * b;
      pos_x      = 0;
      pos_y      = b;
      slope_x    = 0;
      slope_y    = 2 * sq_a * b;
      crit       = (4 * (sq_b - sq_a * b) + sq_a) / 4;
      walk_state = WALK_UPPER;
      return 1'b0;
    end
    case (walk_state)
      WALK_UPPER: begin
        px = pos_x;
        py = pos_y;
        if (slope_x < slope_y) begin
          pos_x   += 1;
          slope_x += 2 * sq_b;
          if (crit < 0) begin
            crit += slope_x + sq_b;
          end else begin
            pos_y   -= 1;
            slope_y -= 2 * sq_a;
            crit    += slope_x + sq_b - slope_y;
          end
        end else begin
          // region change: reload the decision at the half-pixel below
          fin        = (pos_y <= 0);
          tx         = 2 * pos_x + 1;
          ty         = pos_y - 1;
          crit       = (sq_b * tx * tx + 4 * sq_a * ty * ty - 4 * sq_a * sq_b) / 4;
          walk_state = fin ? WALK_IDLE : WALK_LOWER;
        end
        return 1'b1;
      end
      WALK_LOWER: begin
        pos_y   -= 1;
        slope_y -= 2 * sq_a;
        if (crit >= 0) begin
          crit += sq_a - slope_y;
        end else begin
          pos_x   += 1;
          slope_x += 2 * sq_b;
          crit    += slope_x - slope_y + sq_a;
        end
        fin = (pos_y <= 0);
        px  = pos_x;
        py  = pos_y;
        if (fin) walk_state = WALK_IDLE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [AXIS_W-1:0] data);
    dir_row_t r;
    r         = '{default: 0};
    r.is_cfg  = 1'b1;
    r.idx     = idx;
    r.data    = data;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cmd(bit rs, bit has_exp, int ex, int ey, bit edone);
    dir_row_t r;
    r         = '{default: 0};
    r.rs      = rs;
    r.has_exp = has_exp;
    r.ex      = ex;
    r.ey      = ey;
    r.edone   = edone;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '1;
    else if (r < 14) return AXIS_W'(1);
    else if (r < 18) return '0;
    else if (r < 24) return AXIS_W'($urandom_range(21, 1023));
    else return AXIS_W'($urandom_range(1, 20));
  endfunction

  // Register write while the block is idle; starts and ends at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AXIS_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_SEMI_AXIS_X) axis_a_reg = data;
    else axis_b_reg = data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering commands until every pixel is in, then let the block settle
  task automatic drain_pixels();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  // One command transfer; took is set when the command was not ignored
  task automatic send_cmd(input bit rs, input bit has_exp, input int ex, input int ey,
                          input bit edone, output bit took);
    longint px, py;
    bit     fin;
    bit     emitted;
    int     gap;
    gap = 0;
    if ($urandom_range(99) < tx_gap_pct) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= rs;
    do @(posedge clk); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    emitted = step_outline(rs, px, py, fin);
    if (has_exp) queue_pixel_set(ex, ey, edone);
    else if (emitted) queue_pixel_set(px, py, fin);
    took = rs | emitted;
    @(negedge clk);
  endtask

  // Pixel sink: random stalls plus one long hold-off on request
  initial begin : pixel_sink
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0 && !hold_taken) begin
        hold_left  = hold_request;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Compare each pixel transfer with the oldest expected pixel
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel (%0d,%0d)", out_ch.point_x, out_ch.point_y);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.point_x !== want.px) begin
          $error("point_x: expected %0d, got %0d", want.px, out_ch.point_x);
          fail_count++;
        end
        if (out_ch.point_y !== want.py) begin
          $error("point_y: expected %0d, got %0d", want.py, out_ch.point_y);
          fail_count++;
        end
        if (out_ch.last_of_set !== want.last) begin
          $error("last_of_set: expected %0b, got %0b", want.last, out_ch.last_of_set);
          fail_count++;
        end
        if (out_ch.outline_done !== want.done) begin
          $error("outline_done: expected %0b, got %0b", want.done, out_ch.outline_done);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("midpoint_ellipse_rasterizer_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bit                took;
    int                items_done;
    int                phase_no;
    int                steps;
    int                step_cap;
    logic [AXIS_W-1:0] ax, by;
    dir_row_t          row;

    in_ch.valid   = 1'b0;
    in_ch.restart = ADVANCE;
    cfg_write     = 1'b0;
    cfg_index     = REG_SEMI_AXIS_X;
    cfg_data      = '0;

    // Directed table; typed points are the first point of a set
    add_cmd(ADVANCE, 0, 0, 0, 0);        // no walk yet: ignored
    add_cmd(RESTART, 0, 0, 0, 0);        // reset axes 350/250
    add_cmd(ADVANCE, 1, 0, 250, 0);
    add_cmd(ADVANCE, 0, 0, 0, 0);
    add_cmd(ADVANCE, 0, 0, 0, 0);
    add_cfg(REG_SEMI_AXIS_X, 10'd1);
    add_cfg(REG_SEMI_AXIS_Y, 10'd1);
    add_cmd(RESTART, 0, 0, 0, 0);
    add_cmd(ADVANCE, 1, 0, 1, 0);
    add_cmd(ADVANCE, 1, 1, 0, 1);        // region change on y = 0 ends the walk
    add_cmd(ADVANCE, 0, 0, 0, 0);        // after the final set: ignored
    add_cfg(REG_SEMI_AXIS_X, 10'd1023);
    add_cfg(REG_SEMI_AXIS_Y, 10'd1023);
    add_cmd(RESTART, 0, 0, 0, 0);
    add_cmd(ADVANCE, 1, 0, 1023, 0);
    add_cmd(ADVANCE, 0, 0, 0, 0);
    add_cmd(ADVANCE, 0, 0, 0, 0);
    add_cmd(RESTART, 0, 0, 0, 0);        // restart inside region one
    add_cmd(ADVANCE, 1, 0, 1023, 0);
    add_cmd(ADVANCE, 0, 0, 0, 0);
    add_cfg(REG_SEMI_AXIS_X, 10'd0);
    add_cfg(REG_SEMI_AXIS_Y, 10'd0);
    add_cmd(RESTART, 0, 0, 0, 0);
    add_cmd(ADVANCE, 1, 0, 0, 1);        // degenerate ellipse: one final point
    add_cfg(REG_SEMI_AXIS_Y, 10'd1023);
    add_cmd(RESTART, 0, 0, 0, 0);
    add_cmd(ADVANCE, 1, 0, 1023, 0);     // a = 0 goes straight to region two
    add_cmd(ADVANCE, 0, 0, 0, 0);
    add_cmd(RESTART, 0, 0, 0, 0);        // restart inside region two
    add_cmd(ADVANCE, 1, 0, 1023, 0);
    add_cfg(REG_SEMI_AXIS_X, 10'd1023);
    add_cfg(REG_SEMI_AXIS_Y, 10'd1);
    add_cmd(RESTART, 0, 0, 0, 0);
    add_cmd(ADVANCE, 1, 0, 1, 0);
    add_cmd(ADVANCE, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        drain_pixels();
        write_reg(row.idx, row.data);
      end else begin
        send_cmd(row.rs, row.has_exp, row.ex, row.ey, row.edone, took);
      end
    end

    // Random walks, one idling pattern per phase
    phase_no   = 0;
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      drain_pixels();
      case (phase_no % 4)
        0: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_gap_pct   = 46;
          rx_stall_pct = 0;
        end
        2: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 46;
        end
        default: begin
          tx_gap_pct   = 38;
          rx_stall_pct = 38;
        end
      endcase

      ax = pick_axis();
      by = pick_axis();
      if (phase_no == 1) begin
        // full walk of a mid-size ellipse behind the long hold-off
        ax = AXIS_W'($urandom_range(8, 20));
        by = AXIS_W'($urandom_range(8, 20));
      end
      if (phase_no <= 1 || $urandom_range(99) < 85) write_reg(REG_SEMI_AXIS_X, ax);
      if (phase_no <= 1 || $urandom_range(99) < 85) write_reg(REG_SEMI_AXIS_Y, by);
      step_cap = (axis_a_reg > SMALL_AXIS_MAX || axis_b_reg > SMALL_AXIS_MAX) ?
                 CAPPED_STEPS : FREE_STEPS;
      if (phase_no == 1) hold_request = LONG_HOLD;

      repeat ($urandom_range(1, 2)) begin
        send_cmd(RESTART, 0, 0, 0, 0, took);
        items_done++;
        steps = 0;
        // mostly advances, with the odd restart mid-walk
        while (walk_state != WALK_IDLE && steps < step_cap && items_done < RANDOM_ITEMS) begin
          send_cmd(($urandom_range(99) < 4) ? RESTART : ADVANCE, 0, 0, 0, 0, took);
          if (took) items_done++;
          steps++;
        end
        if ($urandom_range(99) < 30) begin
          repeat ($urandom_range(1, 2)) begin
            send_cmd(ADVANCE, 0, 0, 0, 0, took);
            if (took) items_done++;
          end
        end
      end
      phase_no++;
    end

    drain_pixels();
    if (fail_count == 0) begin
      $display("midpoint_ellipse_rasterizer_tb OK");
    end else begin
      $display("midpoint_ellipse_rasterizer_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/mer_pkg.sv
sv/mer_in_if.sv
sv/mer_out_if.sv
sv/midpoint_ellipse_rasterizer.sv
verif/midpoint_ellipse_rasterizer_tb.sv
